// File: hw/rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the two-wire sensor master
// Payload structs, configuration struct, register reset values and the
// start pattern tables used by the bus sequencer.
// ----------------------------------------------------------------------------
package tws_pkg;

   // input transaction: one pin tick
   typedef struct packed {
      logic start_req;
      logic measure_humidity;
      logic data_in;
   } tws_req_type;

   // result transaction: pin drives and status
   typedef struct packed {
      logic        clock_out;
      logic        data_out;
      logic        data_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] raw_value;
      logic [2:0]  error_flags;
   } tws_rsp_type;

   // configuration registers as seen by the sequencer
   typedef struct packed {
      logic [7:0]  temperature_command;
      logic [7:0]  humidity_command;
      logic [15:0] poll_interval_ticks;
      logic [15:0] max_polls;
   } tws_cfg_type;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [7:0]  TEMP_CMD_RESET      = 8'd3;
   localparam logic [7:0]  HUM_CMD_RESET       = 8'd5;
   localparam logic [15:0] POLL_INTERVAL_RESET = 16'd2000;
   localparam logic [15:0] MAX_POLLS_RESET     = 16'd1000;

   // start pattern, bit i is the level on tick i of the pattern
   localparam logic [7:0] START_CLK_PATTERN  = 8'b0011_0110;
   localparam logic [7:0] START_DATA_PATTERN = 8'b0110_0011;

endpackage

// File: hw/rtl/tws_csr.sv
// ----------------------------------------------------------------------------
// tws_csr: configuration register file
// APB-style write and read of the command bytes, poll interval and poll limit.
// ----------------------------------------------------------------------------
module tws_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tws_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [tws_pkg::CsrDataWidth-1:0] pwdata,
   output logic [tws_pkg::CsrDataWidth-1:0] prdata,
   output tws_pkg::tws_cfg_type            cfg
);
   import tws_pkg::*;

   typedef enum logic [1:0] {
      REG_TEMP_CMD,
      REG_HUM_CMD,
      REG_POLL_INTERVAL,
      REG_MAX_POLLS
   } reg_index_type;

   tws_cfg_type   cfg_ff;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index = reg_index_type'(paddr[3:2]);
   assign write_en  = psel & penable & pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temperature_command <= TEMP_CMD_RESET;
         cfg_ff.humidity_command    <= HUM_CMD_RESET;
         cfg_ff.poll_interval_ticks <= POLL_INTERVAL_RESET;
         cfg_ff.max_polls           <= MAX_POLLS_RESET;
      end else if (write_en) begin
         case (reg_index)
            REG_TEMP_CMD:      cfg_ff.temperature_command <= pwdata[7:0];
            REG_HUM_CMD:       cfg_ff.humidity_command    <= pwdata[7:0];
            REG_POLL_INTERVAL: cfg_ff.poll_interval_ticks <= pwdata[15:0];
            REG_MAX_POLLS:     cfg_ff.max_polls           <= pwdata[15:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         REG_TEMP_CMD:      prdata = {24'd0, cfg_ff.temperature_command};
         REG_HUM_CMD:       prdata = {24'd0, cfg_ff.humidity_command};
         REG_POLL_INTERVAL: prdata = {16'd0, cfg_ff.poll_interval_ticks};
         REG_MAX_POLLS:     prdata = {16'd0, cfg_ff.max_polls};
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/tws_seq.sv
// ----------------------------------------------------------------------------
// tws_seq: bus sequencer
// Advances the measurement sequence by one tick per accepted transaction and
// computes the pin drives and status for that tick.
// ----------------------------------------------------------------------------
module tws_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tws_pkg::tws_req_type req,
   input  tws_pkg::tws_cfg_type cfg,
   output tws_pkg::tws_rsp_type rsp
);
   import tws_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_START = 5'd1,
      PH_CSET = 5'd2,
      PH_CHI = 5'd3,
      PH_CLO = 5'd4,
      PH_AHI = 5'd5,
      PH_AREL = 5'd6,
      PH_ALO = 5'd7,
      PH_WAIT = 5'd8,
      PH_R1HI = 5'd9,
      PH_R1LO = 5'd10,
      PH_MD1 = 5'd11,
      PH_MD0 = 5'd12,
      PH_MCH = 5'd13,
      PH_MCL = 5'd14,
      PH_R2HI = 5'd15,
      PH_R2LO = 5'd16,
      PH_KD1 = 5'd17,
      PH_KCH = 5'd18,
      PH_KCL = 5'd19
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [3:0]  bit_counter_ff, bit_counter_in;
   logic [7:0]  command_shift_ff, command_shift_in;
   logic [15:0] read_shift_ff, read_shift_in;
   logic [15:0] interval_counter_ff, interval_counter_in;
   logic [15:0] poll_counter_ff, poll_counter_in;
   logic [2:0]  error_bits_ff, error_bits_in;
   logic [15:0] interval_limit, poll_limit;
   logic [3:0]  bit_counter_inc;

   // zero limits count as one
   assign interval_limit = (cfg.poll_interval_ticks == 16'd0) ? 16'd1
                                                               : cfg.poll_interval_ticks;
   assign poll_limit     = (cfg.max_polls == 16'd0) ? 16'd1 : cfg.max_polls;
   assign bit_counter_inc = bit_counter_ff + 4'd1;

   // next state and pin drives for this tick
   always_comb begin
      phase_in            = phase_ff;
      bit_counter_in      = bit_counter_ff;
      command_shift_in    = command_shift_ff;
      read_shift_in       = read_shift_ff;
      interval_counter_in = interval_counter_ff;
      poll_counter_in     = poll_counter_ff;
      error_bits_in       = error_bits_ff;
      rsp.clock_out       = 1'b0;
      rsp.data_out        = 1'b0;
      rsp.data_drive      = 1'b0;
      rsp.busy_res        = 1'b1;
      rsp.done_res        = 1'b0;
      cur_phase           = phase_ff;

      // start request from idle begins the start pattern on this tick
      if (phase_ff == PH_IDLE && req.start_req) begin
         command_shift_in = req.measure_humidity ? cfg.humidity_command
                                                 : cfg.temperature_command;
         error_bits_in    = 3'd0;
         bit_counter_in   = 4'd0;
         cur_phase        = PH_START;
      end

      case (cur_phase)
         PH_START: begin
            rsp.clock_out  = START_CLK_PATTERN[bit_counter_in[2:0]];
            rsp.data_out   = START_DATA_PATTERN[bit_counter_in[2:0]];
            rsp.data_drive = 1'b1;
            if (bit_counter_in >= 4'd7) begin
               bit_counter_in = 4'd0;
               phase_in       = PH_CSET;
            end else begin
               bit_counter_in = bit_counter_in + 4'd1;
               phase_in       = PH_START;
            end
         end
         PH_CSET, PH_CHI, PH_CLO: begin
            rsp.data_out   = command_shift_in[~bit_counter_ff[2:0]];
            rsp.data_drive = 1'b1;
            rsp.clock_out  = (cur_phase == PH_CHI);
            if (cur_phase == PH_CSET) begin
               phase_in = PH_CHI;
            end else if (cur_phase == PH_CHI) begin
               phase_in = PH_CLO;
            end else if (bit_counter_inc >= 4'd8) begin
               bit_counter_in = 4'd0;
               phase_in       = PH_AHI;
            end else begin
               bit_counter_in = bit_counter_inc;
               phase_in       = PH_CSET;
            end
         end
         PH_AHI: begin
            rsp.clock_out  = 1'b1;
            rsp.data_out   = command_shift_ff[0];
            rsp.data_drive = 1'b1;
            phase_in       = PH_AREL;
         end
         PH_AREL: begin
            // sensor ack: data must be low
            rsp.clock_out = 1'b1;
            if (req.data_in) error_bits_in[0] = 1'b1;
            phase_in = PH_ALO;
         end
         PH_ALO: begin
            // sensor must release the line after ack
            if (!req.data_in) error_bits_in[1] = 1'b1;
            interval_counter_in = 16'd0;
            poll_counter_in     = 16'd0;
            phase_in            = PH_WAIT;
         end
         PH_WAIT: begin
            interval_counter_in = interval_counter_ff + 16'd1;
            if (interval_counter_in >= interval_limit) begin
               interval_counter_in = 16'd0;
               poll_counter_in     = poll_counter_ff + 16'd1;
               if (!req.data_in || poll_counter_in >= poll_limit) begin
                  if (req.data_in) error_bits_in[2] = 1'b1;
                  bit_counter_in = 4'd0;
                  read_shift_in  = 16'd0;
                  phase_in       = PH_R1HI;
               end
            end
         end
         PH_R1HI, PH_R2HI: begin
            rsp.clock_out = 1'b1;
            read_shift_in = {read_shift_ff[14:0], req.data_in};
            phase_in      = (cur_phase == PH_R1HI) ? PH_R1LO : PH_R2LO;
         end
         PH_R1LO, PH_R2LO: begin
            if (bit_counter_inc >= 4'd8) begin
               bit_counter_in = 4'd0;
               phase_in       = (cur_phase == PH_R1LO) ? PH_MD1 : PH_KD1;
            end else begin
               bit_counter_in = bit_counter_inc;
               phase_in       = (cur_phase == PH_R1LO) ? PH_R1HI : PH_R2HI;
            end
         end
         // master ack between the two bytes
         PH_MD1: begin
            rsp.data_out   = 1'b1;
            rsp.data_drive = 1'b1;
            phase_in       = PH_MD0;
         end
         PH_MD0: begin
            rsp.data_drive = 1'b1;
            phase_in       = PH_MCH;
         end
         PH_MCH: begin
            rsp.clock_out  = 1'b1;
            rsp.data_drive = 1'b1;
            phase_in       = PH_MCL;
         end
         PH_MCL: begin
            rsp.data_drive = 1'b1;
            phase_in       = PH_R2HI;
         end
         // skip crc with ack high
         PH_KD1: begin
            rsp.data_out   = 1'b1;
            rsp.data_drive = 1'b1;
            phase_in       = PH_KCH;
         end
         PH_KCH: begin
            rsp.clock_out  = 1'b1;
            rsp.data_out   = 1'b1;
            rsp.data_drive = 1'b1;
            phase_in       = PH_KCL;
         end
         PH_KCL: begin
            rsp.data_out   = 1'b1;
            rsp.data_drive = 1'b1;
            rsp.done_res   = 1'b1;
            phase_in       = PH_IDLE;
         end
         default: begin
            rsp.busy_res = 1'b0;
            phase_in     = PH_IDLE;
         end
      endcase

      rsp.raw_value   = read_shift_in;
      rsp.error_flags = error_bits_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         bit_counter_ff      <= 4'd0;
         command_shift_ff    <= 8'd0;
         read_shift_ff       <= 16'd0;
         interval_counter_ff <= 16'd0;
         poll_counter_ff     <= 16'd0;
         error_bits_ff       <= 3'd0;
      end else if (step) begin
         phase_ff            <= phase_in;
         bit_counter_ff      <= bit_counter_in;
         command_shift_ff    <= command_shift_in;
         read_shift_ff       <= read_shift_in;
         interval_counter_ff <= interval_counter_in;
         poll_counter_ff     <= poll_counter_in;
         error_bits_ff       <= error_bits_in;
      end
   end

endmodule

// File: hw/rtl/two_wire_sensor_measurement_master_top.sv
// ----------------------------------------------------------------------------
// two_wire_sensor_measurement_master_top: two-wire sensor bus master
// Tick-driven measurement sequencer with configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Each req transaction is one pin tick: a start request, the measurement
//   kind and the sampled data line. Each tick yields exactly one rsp
//   transaction with the clock and data drives, busy/done, the raw 16-bit
//   value and the sticky error flags.
//   A tick's result is registered in the output register at the edge that
//   accepts the tick. Throughput is one tick per cycle; req_ready stays
//   high while the output register is empty or is being taken in the
//   same cycle.
//   A stalled receiver holds the result; one more tick is not taken until
//   that result leaves, so the sequencer never runs ahead of the output.
//   Reset puts the sequencer in idle with all counters and flags cleared and
//   loads the default commands, poll interval and poll limit.
//   Registers (APB, byte address 4*i): 0 temperature command, 1 humidity
//   command, 2 poll interval in ticks, 3 poll limit. Write them while idle.
// ----------------------------------------------------------------------------
module two_wire_sensor_measurement_master_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tws_pkg::tws_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tws_pkg::tws_rsp_type             rsp_payload,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tws_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [tws_pkg::CsrDataWidth-1:0] pwdata,
   output logic [tws_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready
);
   import tws_pkg::*;

   tws_cfg_type cfg;
   tws_rsp_type rsp_next;
   tws_rsp_type rsp_payload_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        step;

   assign pready    = 1'b1;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   tws_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   tws_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_payload),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hw/rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker: port-level checks for the two-wire sensor master
// Watches the result channel and pin drives; bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tws_pkg::tws_rsp_type rsp_payload
);
   import tws_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // an empty output register always takes a tick
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // done only inside a sequence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res |-> rsp_payload.busy_res)
      else $error("done without busy");

   // idle ticks leave the bus quiet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.busy_res |->
         !rsp_payload.clock_out && !rsp_payload.data_drive)
      else $error("bus driven while idle");

   // released data line reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.data_drive |-> !rsp_payload.data_out)
      else $error("data level set while released");

endmodule

bind two_wire_sensor_measurement_master_top tws_checker u_tws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: sim/tb_two_wire_sensor_measurement_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_wire_sensor_measurement_master_top: sequencer pin-level testbench
// Drives pin ticks into the two-wire sensor master and checks every result
// transaction against a tick-by-tick software copy of the bus sequencer.
// Directed measurements cover reset defaults, idle ticks, zero limits, ack
// and release errors with extreme commands, wait timeouts, receiver
// hold-off and the largest register values; a random pass mixes measurements
// or line noise under random register settings.
// ----------------------------------------------------------------------------
module tb_two_wire_sensor_measurement_master_top;
   import tws_pkg::*;

   // sequencer phases, same order as the bus walk
   typedef enum logic [4:0] {
      PH_IDLE, PH_START, PH_CMD_SETUP, PH_CMD_HIGH, PH_CMD_LOW,
      PH_ACK_HIGH, PH_ACK_RELEASE, PH_ACK_LOW, PH_WAIT,
      PH_RD1_HIGH, PH_RD1_LOW, PH_MACK_DATA1, PH_MACK_DATA0,
      PH_MACK_CLK_HIGH, PH_MACK_CLK_LOW, PH_RD2_HIGH, PH_RD2_LOW,
      PH_SKIP_DATA, PH_SKIP_CLK_HIGH, PH_SKIP_CLK_LOW
   } seq_phase_type;

   // register indexes
   localparam int REG_TEMP_CMD      = 0;
   localparam int REG_HUM_CMD       = 1;
   localparam int REG_POLL_INTERVAL = 2;
   localparam int REG_MAX_POLLS     = 3;
   localparam int ADDR_STRIDE       = 4;

   // error flag bits
   localparam int ERR_NO_ACK      = 0;
   localparam int ERR_NO_RELEASE  = 1;
   localparam int ERR_WAIT_TIMEOUT = 2;

   // start pattern levels, bit i drives tick i
   localparam logic [7:0] START_CLOCK_LEVELS = 8'b0011_0110;
   localparam logic [7:0] START_DATA_LEVELS  = 8'b0110_0011;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int HOLD_OFF_CYCLES  = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   tws_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tws_rsp_type rsp_payload;

   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   two_wire_sensor_measurement_master_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // sequencer copy used for prediction
   tws_cfg_type   model_cfg;
   seq_phase_type model_phase;
   logic [3:0]    model_bits;
   logic [7:0]    model_cmd;
   logic [15:0]   model_read;
   logic [15:0]   model_interval;
   logic [15:0]   model_polls;
   logic [2:0]    model_err;

   tws_rsp_type pending_pins[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_off_requests = 0;
   int hold_off_taken = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int measurements_done = 0;
   int config_writes = 0;
   int error_count = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_two_wire_sensor_measurement_master_top: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at result %0d",
               what, got, want, results_seen);
   endtask

   task automatic reset_model();
      model_cfg.temperature_command = 8'd3;
      model_cfg.humidity_command    = 8'd5;
      model_cfg.poll_interval_ticks = 16'd2000;
      model_cfg.max_polls           = 16'd1000;
      model_phase    = PH_IDLE;
      model_bits     = '0;
      model_cmd      = '0;
      model_read     = '0;
      model_interval = '0;
      model_polls    = '0;
      model_err      = '0;
   endtask

   // advance the sequencer copy by one tick and return the pin drives
   function automatic tws_rsp_type predict_pins(input tws_req_type tick);
      tws_rsp_type r;
      logic [15:0] lim;
      r = '0;
      r.busy_res = 1'b1;
      if (model_phase == PH_IDLE && tick.start_req) begin
         model_cmd   = tick.measure_humidity ? model_cfg.humidity_command
                                             : model_cfg.temperature_command;
         model_err   = '0;
         model_bits  = '0;
         model_phase = PH_START;
      end
      case (model_phase)
         PH_START: begin
            r.clock_out  = START_CLOCK_LEVELS[model_bits[2:0]];
            r.data_out   = START_DATA_LEVELS[model_bits[2:0]];
            r.data_drive = 1'b1;
            if (model_bits >= 4'd7) begin
               model_bits  = '0;
               model_phase = PH_CMD_SETUP;
            end else begin
               model_bits = model_bits + 4'd1;
            end
         end
         PH_CMD_SETUP, PH_CMD_HIGH, PH_CMD_LOW: begin
            r.data_out   = model_cmd[3'd7 - model_bits[2:0]];
            r.data_drive = 1'b1;
            r.clock_out  = (model_phase == PH_CMD_HIGH);
            if (model_phase == PH_CMD_SETUP) begin
               model_phase = PH_CMD_HIGH;
            end else if (model_phase == PH_CMD_HIGH) begin
               model_phase = PH_CMD_LOW;
            end else begin
               model_bits = model_bits + 4'd1;
               if (model_bits >= 4'd8) begin
                  model_bits  = '0;
                  model_phase = PH_ACK_HIGH;
               end else begin
                  model_phase = PH_CMD_SETUP;
               end
            end
         end
         PH_ACK_HIGH: begin
            r.clock_out  = 1'b1;
            r.data_out   = model_cmd[0];
            r.data_drive = 1'b1;
            model_phase  = PH_ACK_RELEASE;
         end
         PH_ACK_RELEASE: begin
            r.clock_out = 1'b1;
            if (tick.data_in) model_err[ERR_NO_ACK] = 1'b1;
            model_phase = PH_ACK_LOW;
         end
         PH_ACK_LOW: begin
            if (!tick.data_in) model_err[ERR_NO_RELEASE] = 1'b1;
            model_interval = '0;
            model_polls    = '0;
            model_phase    = PH_WAIT;
         end
         PH_WAIT: begin
            model_interval = model_interval + 16'd1;
            lim = (model_cfg.poll_interval_ticks == '0) ? 16'd1
                                                        : model_cfg.poll_interval_ticks;
            if (model_interval >= lim) begin
               model_interval = '0;
               model_polls    = model_polls + 16'd1;
               lim = (model_cfg.max_polls == '0) ? 16'd1 : model_cfg.max_polls;
               if (!tick.data_in || model_polls >= lim) begin
                  if (tick.data_in) model_err[ERR_WAIT_TIMEOUT] = 1'b1;
                  model_bits  = '0;
                  model_read  = '0;
                  model_phase = PH_RD1_HIGH;
               end
            end
         end
         PH_RD1_HIGH, PH_RD2_HIGH: begin
            r.clock_out = 1'b1;
            model_read  = {model_read[14:0], tick.data_in};
            model_phase = (model_phase == PH_RD1_HIGH) ? PH_RD1_LOW : PH_RD2_LOW;
         end
         PH_RD1_LOW, PH_RD2_LOW: begin
            model_bits = model_bits + 4'd1;
            if (model_bits >= 4'd8) begin
               model_bits  = '0;
               model_phase = (model_phase == PH_RD1_LOW) ? PH_MACK_DATA1 : PH_SKIP_DATA;
            end else begin
               model_phase = (model_phase == PH_RD1_LOW) ? PH_RD1_HIGH : PH_RD2_HIGH;
            end
         end
         PH_MACK_DATA1: begin
            r.data_out   = 1'b1;
            r.data_drive = 1'b1;
            model_phase  = PH_MACK_DATA0;
         end
         PH_MACK_DATA0: begin
            r.data_drive = 1'b1;
            model_phase  = PH_MACK_CLK_HIGH;
         end
         PH_MACK_CLK_HIGH: begin
            r.clock_out  = 1'b1;
            r.data_drive = 1'b1;
            model_phase  = PH_MACK_CLK_LOW;
         end
         PH_MACK_CLK_LOW: begin
            r.data_drive = 1'b1;
            model_phase  = PH_RD2_HIGH;
         end
         PH_SKIP_DATA: begin
            r.data_out   = 1'b1;
            r.data_drive = 1'b1;
            model_phase  = PH_SKIP_CLK_HIGH;
         end
         PH_SKIP_CLK_HIGH: begin
            r.clock_out  = 1'b1;
            r.data_out   = 1'b1;
            r.data_drive = 1'b1;
            model_phase  = PH_SKIP_CLK_LOW;
         end
         PH_SKIP_CLK_LOW: begin
            r.data_out   = 1'b1;
            r.data_drive = 1'b1;
            r.done_res   = 1'b1;
            model_phase  = PH_IDLE;
         end
         default: begin
            r.busy_res  = 1'b0;
            model_phase = PH_IDLE;
         end
      endcase
      r.raw_value   = model_read;
      r.error_flags = model_err;
      return r;
   endfunction

   // receiver: random stalls plus a long counted hold-off on request
   always @(negedge clock) begin
      if (hold_off_requests != hold_off_taken) begin
         hold_off_taken = hold_off_requests;
         hold_left      = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // check each result transaction against the oldest prediction
   always @(posedge clock) begin
      tws_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_seen++;
         if (pending_pins.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(rsp_payload), '0);
         end else begin
            want = pending_pins.pop_front();
            if (rsp_payload.clock_out !== want.clock_out)
               report_mismatch("clock_out", 32'(rsp_payload.clock_out),
                               32'(want.clock_out));
            if (rsp_payload.data_out !== want.data_out)
               report_mismatch("data_out", 32'(rsp_payload.data_out),
                               32'(want.data_out));
            if (rsp_payload.data_drive !== want.data_drive)
               report_mismatch("data_drive", 32'(rsp_payload.data_drive),
                               32'(want.data_drive));
            if (rsp_payload.busy_res !== want.busy_res)
               report_mismatch("busy_res", 32'(rsp_payload.busy_res),
                               32'(want.busy_res));
            if (rsp_payload.done_res !== want.done_res)
               report_mismatch("done_res", 32'(rsp_payload.done_res),
                               32'(want.done_res));
            if (rsp_payload.raw_value !== want.raw_value)
               report_mismatch("raw_value", 32'(rsp_payload.raw_value),
                               32'(want.raw_value));
            if (rsp_payload.error_flags !== want.error_flags)
               report_mismatch("error_flags", 32'(rsp_payload.error_flags),
                               32'(want.error_flags));
            if (want.done_res) measurements_done++;
         end
      end
   end

   // one tick transaction; starts and ends at a falling edge, valid left high
   task automatic send_tick(input tws_req_type tick);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= tick;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_pins.push_back(predict_pins(tick));
      ticks_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait for every predicted result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrWidth'(idx * ADDR_STRIDE);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      case (idx)
         REG_TEMP_CMD:      model_cfg.temperature_command = value[7:0];
         REG_HUM_CMD:       model_cfg.humidity_command    = value[7:0];
         REG_POLL_INTERVAL: model_cfg.poll_interval_ticks = value[15:0];
         REG_MAX_POLLS:     model_cfg.max_polls           = value[15:0];
         default: ;
      endcase
      config_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read_check(input int idx, input logic [31:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CsrAddrWidth'(idx * ADDR_STRIDE);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (prdata !== want) report_mismatch("register readback", prdata, want);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_registers();
      csr_read_check(REG_TEMP_CMD,      {24'd0, model_cfg.temperature_command});
      csr_read_check(REG_HUM_CMD,       {24'd0, model_cfg.humidity_command});
      csr_read_check(REG_POLL_INTERVAL, {16'd0, model_cfg.poll_interval_ticks});
      csr_read_check(REG_MAX_POLLS,     {16'd0, model_cfg.max_polls});
   endtask

   // registers change only with the sequencer idle and nothing in flight
   task automatic write_config(input logic [7:0] temp_cmd, input logic [7:0] hum_cmd,
                               input logic [15:0] interval, input logic [15:0] polls);
      drain_results();
      csr_write(REG_TEMP_CMD,      {24'd0, temp_cmd});
      csr_write(REG_HUM_CMD,       {24'd0, hum_cmd});
      csr_write(REG_POLL_INTERVAL, {16'd0, interval});
      csr_write(REG_MAX_POLLS,     {16'd0, polls});
      check_registers();
   endtask

   // feed the sensor side of a sequence until the master returns to idle
   task automatic follow_sequence(input bit ack_bad, input bit release_bad,
                                  input int ready_poll, input int stray_pct,
                                  input int pause_at);
      tws_req_type tick;
      logic [15:0] interval_lim;
      int          step;
      step = 0;
      while (model_phase != PH_IDLE) begin
         tick.start_req        = ($urandom_range(0, 99) < stray_pct);
         tick.measure_humidity = 1'($urandom_range(0, 1));
         tick.data_in          = 1'($urandom_range(0, 1));
         case (model_phase)
            PH_ACK_RELEASE: tick.data_in = ack_bad;
            PH_ACK_LOW:     tick.data_in = ~release_bad;
            PH_WAIT: begin
               interval_lim = (model_cfg.poll_interval_ticks == '0) ? 16'd1
                                                                    : model_cfg.poll_interval_ticks;
               // data goes low at the poll numbered ready_poll
               if (model_interval + 16'd1 >= interval_lim)
                  tick.data_in = (model_polls + 1 < ready_poll);
            end
            default: ;
         endcase
         if (step == pause_at) drain_results();
         send_tick(tick);
         step++;
      end
   endtask

   task automatic run_measurement(input logic humid, input bit ack_bad, input bit release_bad,
                                  input int ready_poll, input int stray_pct,
                                  input int pause_at);
      tws_req_type tick;
      tick.start_req        = 1'b1;
      tick.measure_humidity = humid;
      tick.data_in          = 1'($urandom_range(0, 1));
      send_tick(tick);
      follow_sequence(ack_bad, release_bad, ready_poll, stray_pct, pause_at);
   endtask

   // fully random ticks, then whatever sequence they started runs out
   task automatic send_line_noise(input int count);
      tws_req_type tick;
      repeat (count) begin
         tick.start_req        = ($urandom_range(0, 3) == 0);
         tick.measure_humidity = 1'($urandom_range(0, 1));
         tick.data_in          = 1'($urandom_range(0, 1));
         send_tick(tick);
      end
      follow_sequence(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(1, 7), 25, -1);
   endtask

   // register values straight after reset
   task automatic test_reset_defaults();
      check_registers();
   endtask

   // idle ticks keep the lines released whatever the inputs say
   task automatic test_idle_ticks();
      tws_req_type tick;
      for (int k = 0; k < 4; k++) begin
         tick.start_req        = 1'b0;
         tick.measure_humidity = k[1];
         tick.data_in          = k[0];
         send_tick(tick);
      end
   endtask

   // zero interval and zero poll limit both act as one, default commands kept
   task automatic test_zero_limits();
      write_config(TEMP_CMD_RESET, HUM_CMD_RESET, 16'd0, 16'd0);
      run_measurement(1'b1, 1'b0, 1'b0, 3, 0, -1);
   endtask

   // missing ack and line not released, sent with an all-zero command
   task automatic test_ack_errors();
      write_config(8'h00, 8'hFF, 16'd1, 16'd2);
      run_measurement(1'b0, 1'b1, 1'b1, 1, 0, -1);
   endtask

   // data never goes low; flags from the run before are cleared
   task automatic test_wait_timeout();
      write_config(8'h81, 8'h18, 16'd3, 16'd2);
      run_measurement(1'b0, 1'b0, 1'b0, 100, 0, -1);
   endtask

   // long receiver hold-off while ticks keep coming, then a mid-sequence pause
   task automatic test_backpressure();
      write_config(8'h0F, 8'hF0, 16'd1, 16'd2);
      hold_off_requests++;
      run_measurement(1'b1, 1'b0, 1'b0, 2, 10, 30);
   endtask

   // largest register values, then an all-ones command with start requests
   // arriving while busy
   task automatic test_max_limits();
      write_config(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF);
      write_config(8'hFF, 8'h00, 16'd1, 16'hFFFF);
      run_measurement(1'b0, 1'b0, 1'b0, 4, 50, -1);
   endtask

   task automatic test_random_traffic(input int n_ticks);
      int stop_at;
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 2) == 0)
            write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 6)), 16'($urandom_range(0, 5)));
         if ($urandom_range(0, 9) < 8)
            run_measurement(1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0),
                            ($urandom_range(0, 5) == 0), $urandom_range(1, 7), 20, -1);
         else
            send_line_noise($urandom_range(1, 24));
      end
   endtask

   initial begin
      reset_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 10;
      rsp_idle_pct = 65;
      test_reset_defaults();
      test_idle_ticks();
      test_zero_limits();
      test_ack_errors();

      req_idle_pct = 65;
      rsp_idle_pct = 10;
      test_wait_timeout();
      test_backpressure();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_max_limits();
      test_random_traffic(20);

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_pins.size() != 0)
         report_mismatch("results never arrived", pending_pins.size(), '0);

      $display("run covered %0d ticks and %0d finished measurements over three stall mixes",
               ticks_sent, measurements_done);
      $display("%0d register writes, %0d results checked, %0d mismatches",
               config_writes, results_seen, error_count);
      if (error_count == 0) begin
         $display("tb_two_wire_sensor_measurement_master_top: done, clean");
      end else begin
         $display("tb_two_wire_sensor_measurement_master_top: done, errors");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tws_pkg.sv
hw/rtl/tws_csr.sv
hw/rtl/tws_seq.sv
hw/rtl/two_wire_sensor_measurement_master_top.sv
hw/rtl/tws_checker.sv
sim/tb_two_wire_sensor_measurement_master_top.sv
